### hw/rtl/sls_pkg.sv
// shared types and constants for the spring stretch limit unit
`timescale 1ns / 1ps
package sls_pkg;

   localparam int FRAC_BITS = 16;
   localparam int POS_W     = 32;
   localparam int REST_W    = 31;
   localparam int IDX_W     = 10;
   localparam int SQ_W      = 2 * POS_W + 2;
   localparam int DIST_W    = POS_W + 1;
   localparam int SQRT_STAGES = DIST_W;
   localparam int SREM_W    = DIST_W + 3;
   localparam int STR_W     = DIST_W + 2;
   localparam int C10_W     = STR_W + 5;
   localparam int CM_W      = 38;
   localparam int DEN_W     = 38;
   localparam int Q_W       = 36;
   localparam int NUM_W     = 72;
   localparam int SUM_W     = 39;
   // smallest distance that is not below 1e-6 in fixed point
   localparam int TINY_LIM  = ((1 << FRAC_BITS) + 999999) / 1000000;

   typedef struct packed {
      logic [POS_W-1:0]  p1x;
      logic [POS_W-1:0]  p1y;
      logic [POS_W-1:0]  p1z;
      logic [POS_W-1:0]  p2x;
      logic [POS_W-1:0]  p2y;
      logic [POS_W-1:0]  p2z;
      logic              pin1;
      logic              pin2;
      logic [REST_W-1:0] rest;
      logic [IDX_W-1:0]  idx1;
      logic [IDX_W-1:0]  idx2;
   } item_type;

   typedef struct packed {
      item_type item;
      logic     move;
      logic     c_neg;
   } ctl_type;

endpackage

### hw/rtl/sls_front.sv
// endpoint deltas, squared components and their sum
`timescale 1ns / 1ps
module sls_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  sls_pkg::item_type        in_item,
   output logic                     out_valid,
   output logic [sls_pkg::SQ_W-1:0] out_sumsq,
   output sls_pkg::item_type        out_item
);
   import sls_pkg::*;

   logic [2:0]           valid_ff;
   item_type             item_ff [3];
   logic [POS_W-1:0]     mag_ff [3];
   logic [POS_W-1:0]     mag_in [3];
   logic [2*POS_W-1:0]   sq_ff [3];
   logic [2*POS_W-1:0]   sq_in [3];
   logic [SQ_W-1:0]      sum_ff, sum_in;
   logic [POS_W-1:0]     pa [3];
   logic [POS_W-1:0]     pb [3];

   assign pa[0] = in_item.p1x;
   assign pa[1] = in_item.p1y;
   assign pa[2] = in_item.p1z;
   assign pb[0] = in_item.p2x;
   assign pb[1] = in_item.p2y;
   assign pb[2] = in_item.p2z;

   always_comb begin
      logic [POS_W:0] diff;
      logic [POS_W:0] absv;
      for (int i = 0; i < 3; i++) begin
         diff = {pb[i][POS_W-1], pb[i]} - {pa[i][POS_W-1], pa[i]};
         absv = diff[POS_W] ? (~diff + 1'b1) : diff;
         mag_in[i] = absv[POS_W-1:0];
         sq_in[i] = (2*POS_W)'(mag_ff[i]) * (2*POS_W)'(mag_ff[i]);
      end
      sum_in = SQ_W'(sq_ff[0]) + SQ_W'(sq_ff[1]) + SQ_W'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff[0] <= in_item;
         item_ff[1] <= item_ff[0];
         item_ff[2] <= item_ff[1];
         mag_ff     <= mag_in;
         sq_ff      <= sq_in;
         sum_ff     <= sum_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_sumsq = sum_ff;
   assign out_item  = item_ff[2];

endmodule

### hw/rtl/sls_isqrt.sv
// integer square root, one result bit per pipeline stage
`timescale 1ns / 1ps
module sls_isqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_valid,
   input  logic [sls_pkg::SQ_W-1:0]   in_sumsq,
   input  sls_pkg::item_type          in_item,
   output logic                       out_valid,
   output logic [sls_pkg::DIST_W-1:0] out_dist,
   output sls_pkg::item_type          out_item
);
   import sls_pkg::*;

   logic [SQRT_STAGES-1:0] valid_ff;
   item_type               item_ff [SQRT_STAGES];
   logic [SQ_W-1:0]        rad_ff [SQRT_STAGES];
   logic [SQ_W-1:0]        rad_in [SQRT_STAGES];
   logic [DIST_W-1:0]      root_ff [SQRT_STAGES];
   logic [DIST_W-1:0]      root_in [SQRT_STAGES];
   logic [SREM_W-1:0]      rem_ff [SQRT_STAGES];
   logic [SREM_W-1:0]      rem_in [SQRT_STAGES];

   always_comb begin
      logic [SQ_W-1:0]   src_rad;
      logic [DIST_W-1:0] src_root;
      logic [SREM_W-1:0] src_rem;
      logic [SREM_W-1:0] remx;
      logic [SREM_W-1:0] trial;
      for (int s = 0; s < SQRT_STAGES; s++) begin
         if (s == 0) begin
            src_rad  = in_sumsq;
            src_root = '0;
            src_rem  = '0;
         end else begin
            src_rad  = rad_ff[s-1];
            src_root = root_ff[s-1];
            src_rem  = rem_ff[s-1];
         end
         // bring down the next bit pair of the radicand
         remx  = {src_rem[SREM_W-3:0], src_rad[SQ_W-1:SQ_W-2]};
         trial = (SREM_W'(src_root) << 2) | SREM_W'(1);
         if (remx >= trial) begin
            rem_in[s]  = remx - trial;
            root_in[s] = {src_root[DIST_W-2:0], 1'b1};
         end else begin
            rem_in[s]  = remx;
            root_in[s] = {src_root[DIST_W-2:0], 1'b0};
         end
         rad_in[s] = src_rad << 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[SQRT_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff[0] <= in_item;
         for (int s = 1; s < SQRT_STAGES; s++) begin
            item_ff[s] <= item_ff[s-1];
         end
         rad_ff  <= rad_in;
         root_ff <= root_in;
         rem_ff  <= rem_in;
      end
   end

   assign out_valid = valid_ff[SQRT_STAGES-1];
   assign out_dist  = root_ff[SQRT_STAGES-1];
   assign out_item  = item_ff[SQRT_STAGES-1];

endmodule

### hw/rtl/sls_muldiv.sv
// rounded mag * cm / den for three axes: split multiply then one quotient bit per stage
`timescale 1ns / 1ps
module sls_muldiv (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 adv,
   input  logic                                 in_valid,
   input  sls_pkg::ctl_type                     in_ctl,
   input  logic [2:0][sls_pkg::POS_W-1:0]       in_mag,
   input  logic [sls_pkg::CM_W-1:0]             in_cm,
   input  logic [sls_pkg::DEN_W-1:0]            in_den,
   output logic                                 out_valid,
   output sls_pkg::ctl_type                     out_ctl,
   output logic [2:0][sls_pkg::Q_W-1:0]         out_quo
);
   import sls_pkg::*;

   localparam int NST = Q_W + 2;
   localparam int HI_W = CM_W - 32;

   logic [NST-1:0]               valid_ff;
   ctl_type                      ctl_ff [NST];
   logic [DEN_W-1:0]             den_ff [NST];
   logic [2:0][2*POS_W-1:0]      pplo_ff, pplo_in;
   logic [2:0][POS_W+HI_W-1:0]   pphi_ff, pphi_in;
   logic [2:0][NUM_W-1:0]        num_ff, num_in;
   logic [2:0][DEN_W-1:0]        rem_ff [Q_W];
   logic [2:0][DEN_W-1:0]        rem_in [Q_W];
   logic [2:0][Q_W-1:0]          low_ff [Q_W];
   logic [2:0][Q_W-1:0]          low_in [Q_W];
   logic [2:0][Q_W-1:0]          quo_ff [Q_W];
   logic [2:0][Q_W-1:0]          quo_in [Q_W];

   always_comb begin
      logic [DEN_W-1:0] src_rem;
      logic [Q_W-1:0]   src_low;
      logic [Q_W-1:0]   src_quo;
      logic [DEN_W:0]   remx;
      for (int i = 0; i < 3; i++) begin
         pplo_in[i] = (2*POS_W)'(in_mag[i]) * (2*POS_W)'(in_cm[31:0]);
         pphi_in[i] = (POS_W+HI_W)'(in_mag[i]) * (POS_W+HI_W)'(in_cm[CM_W-1:32]);
         // half the divisor added first gives round to nearest
         num_in[i] = NUM_W'(pplo_ff[i]) + (NUM_W'(pphi_ff[i]) << 32)
                   + NUM_W'(den_ff[0] >> 1);
      end
      for (int s = 0; s < Q_W; s++) begin
         for (int i = 0; i < 3; i++) begin
            if (s == 0) begin
               src_rem = DEN_W'(num_ff[i][NUM_W-1:Q_W]);
               src_low = num_ff[i][Q_W-1:0];
               src_quo = '0;
            end else begin
               src_rem = rem_ff[s-1][i];
               src_low = low_ff[s-1][i];
               src_quo = quo_ff[s-1][i];
            end
            remx = {src_rem, src_low[Q_W-1]};
            if (remx >= {1'b0, den_ff[s+1]}) begin
               rem_in[s][i] = DEN_W'(remx - {1'b0, den_ff[s+1]});
               quo_in[s][i] = {src_quo[Q_W-2:0], 1'b1};
            end else begin
               rem_in[s][i] = remx[DEN_W-1:0];
               quo_in[s][i] = {src_quo[Q_W-2:0], 1'b0};
            end
            low_in[s][i] = src_low << 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[NST-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl_ff[0] <= in_ctl;
         den_ff[0] <= in_den;
         for (int s = 1; s < NST; s++) begin
            ctl_ff[s] <= ctl_ff[s-1];
            den_ff[s] <= den_ff[s-1];
         end
         pplo_ff <= pplo_in;
         pphi_ff <= pphi_in;
         num_ff  <= num_in;
         rem_ff  <= rem_in;
         low_ff  <= low_in;
         quo_ff  <= quo_in;
      end
   end

   assign out_valid = valid_ff[NST-1];
   assign out_ctl   = ctl_ff[NST-1];
   assign out_quo   = quo_ff[Q_W-1];

endmodule

### hw/rtl/spring_stretch_limit_unit.sv
// top level: stretch limiter for one distance spring per transfer
//
// req channel carries one spring (both endpoints, anchored flags, rest length,
// vertex indices); rsp channel returns both corrected endpoints, a corrected
// flag and the echoed indices. Both are valid/ready streams; a transfer takes
// place when tvalid and tready are high at a rising clock edge.
// From a req transfer to rsp_tvalid, a spring passes through the deltas and
// squares, the square root (one root bit per stage), the stretch test, the
// split multiply and the move divider (one quotient bit per stage) and the
// output register.
// Throughput is one spring per cycle while rsp_tready stays high.
// When the receiver stalls with a result held, the whole pipeline freezes and
// req_tready drops; nothing is lost or repeated.
// Synchronous reset clears all valid bits; the pipeline is empty afterwards.
`timescale 1ns / 1ps
module spring_stretch_limit_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // first_x, first_y, first_z, second_x, second_y, second_z, first_pinned,
   // second_pinned, rest_len, first_index, second_index, zero pad
   input  logic [247:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // new_first_x, new_first_y, new_first_z, new_second_x, new_second_y,
   // new_second_z, was_corrected, out_first_index, out_second_index, zero pad
   output logic [215:0] rsp_tdata
);
   import sls_pkg::*;

   logic              adv;
   item_type          req_item;
   logic              fr_valid;
   logic [SQ_W-1:0]   fr_sumsq;
   item_type          fr_item;
   logic              sq_valid;
   logic [DIST_W-1:0] sq_dist;
   item_type          sq_item;

   // post-root stages
   logic              p1_valid_ff, p2_valid_ff, p3_valid_ff;
   item_type          p1_item_ff, p2_item_ff;
   ctl_type           p3_ctl_ff, p3_ctl_in;
   logic signed [STR_W-1:0] p1_str_ff, p1_str_in;
   logic              p1_tiny_ff, p1_tiny_in, p2_tiny_ff;
   logic [DEN_W-1:0]  p1_den_ff, p1_den_in, p2_den_ff, p3_den_ff;
   logic [2:0][POS_W-1:0] p1_mag_ff, p1_mag_in, p2_mag_ff, p3_mag_ff;
   logic signed [C10_W-1:0] p2_c10_ff, p2_c10_in;
   logic              p2_spos_ff, p2_sneg_ff;
   logic [CM_W-1:0]   p3_cm_ff, p3_cm_in;

   logic              md_valid;
   ctl_type           md_ctl;
   logic [2:0][Q_W-1:0] md_quo;

   logic              rsp_valid_ff;
   logic [215:0]      rsp_data_ff, rsp_data_in;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign req_item.p1x  = req_tdata[31:0];
   assign req_item.p1y  = req_tdata[63:32];
   assign req_item.p1z  = req_tdata[95:64];
   assign req_item.p2x  = req_tdata[127:96];
   assign req_item.p2y  = req_tdata[159:128];
   assign req_item.p2z  = req_tdata[191:160];
   assign req_item.pin1 = req_tdata[192];
   assign req_item.pin2 = req_tdata[193];
   assign req_item.rest = req_tdata[224:194];
   assign req_item.idx1 = req_tdata[234:225];
   assign req_item.idx2 = req_tdata[244:235];

   sls_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .in_item   (req_item),
      .out_valid (fr_valid),
      .out_sumsq (fr_sumsq),
      .out_item  (fr_item)
   );

   sls_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fr_valid),
      .in_sumsq  (fr_sumsq),
      .in_item   (fr_item),
      .out_valid (sq_valid),
      .out_dist  (sq_dist),
      .out_item  (sq_item)
   );

   // stage p1: stretch, tiny test, divisor, per-axis magnitudes
   always_comb begin
      logic [POS_W-1:0] pa [3];
      logic [POS_W-1:0] pb [3];
      logic [POS_W:0]   diff;
      logic [POS_W:0]   absv;
      logic [DEN_W-1:0] den10;
      pa[0] = sq_item.p1x;
      pa[1] = sq_item.p1y;
      pa[2] = sq_item.p1z;
      pb[0] = sq_item.p2x;
      pb[1] = sq_item.p2y;
      pb[2] = sq_item.p2z;
      for (int i = 0; i < 3; i++) begin
         diff = {pb[i][POS_W-1], pb[i]} - {pa[i][POS_W-1], pa[i]};
         absv = diff[POS_W] ? (~diff + 1'b1) : diff;
         p1_mag_in[i] = absv[POS_W-1:0];
      end
      p1_str_in  = $signed({2'b00, sq_dist}) - $signed({4'b0000, sq_item.rest});
      p1_tiny_in = sq_dist < DIST_W'(TINY_LIM);
      den10      = (DEN_W'(sq_dist) << 3) + (DEN_W'(sq_dist) << 1);
      // shared correction halves the move
      p1_den_in  = (!sq_item.pin1 && !sq_item.pin2) ? (den10 << 1) : den10;
   end

   // stage p2: excess in tenths
   always_comb begin
      logic signed [C10_W-1:0] s10;
      logic signed [C10_W-1:0] rest_ext;
      s10      = (C10_W'(p1_str_ff) <<< 3) + (C10_W'(p1_str_ff) <<< 1);
      rest_ext = $signed({{(C10_W-REST_W){1'b0}}, p1_item_ff.rest});
      p2_c10_in = (p1_str_ff > 0) ? (s10 - rest_ext) : (s10 + rest_ext);
   end

   // stage p3: limit test and magnitude of the excess
   always_comb begin
      logic signed [C10_W-1:0] cabs;
      cabs = p2_c10_ff[C10_W-1] ? -p2_c10_ff : p2_c10_ff;
      p3_cm_in        = cabs[CM_W-1:0];
      p3_ctl_in.item  = p2_item_ff;
      p3_ctl_in.c_neg = p2_c10_ff[C10_W-1];
      p3_ctl_in.move  = !p2_tiny_ff && !(p2_item_ff.pin1 && p2_item_ff.pin2)
                      && ((p2_spos_ff && p2_c10_ff > 0) || (p2_sneg_ff && p2_c10_ff < 0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff <= sq_valid;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_item_ff <= sq_item;
         p1_str_ff  <= p1_str_in;
         p1_tiny_ff <= p1_tiny_in;
         p1_den_ff  <= p1_den_in;
         p1_mag_ff  <= p1_mag_in;
         p2_item_ff <= p1_item_ff;
         p2_c10_ff  <= p2_c10_in;
         p2_spos_ff <= p1_str_ff > 0;
         p2_sneg_ff <= p1_str_ff < 0;
         p2_tiny_ff <= p1_tiny_ff;
         p2_den_ff  <= p1_den_ff;
         p2_mag_ff  <= p1_mag_ff;
         p3_ctl_ff  <= p3_ctl_in;
         p3_cm_ff   <= p3_cm_in;
         p3_den_ff  <= p2_den_ff;
         p3_mag_ff  <= p2_mag_ff;
      end
   end

   sls_muldiv u_muldiv (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (p3_valid_ff),
      .in_ctl    (p3_ctl_ff),
      .in_mag    (p3_mag_ff),
      .in_cm     (p3_cm_ff),
      .in_den    (p3_den_ff),
      .out_valid (md_valid),
      .out_ctl   (md_ctl),
      .out_quo   (md_quo)
   );

   function automatic logic [POS_W-1:0] sat32(input logic [SUM_W-1:0] v);
      if (v[SUM_W-1:POS_W-1] == '0 || v[SUM_W-1:POS_W-1] == '1) begin
         return v[POS_W-1:0];
      end else if (v[SUM_W-1]) begin
         return {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         return {1'b0, {(POS_W-1){1'b1}}};
      end
   endfunction

   // output stage: signed move, apply, saturate
   always_comb begin
      logic [POS_W-1:0]   pa [3];
      logic [POS_W-1:0]   pb [3];
      logic [POS_W-1:0]   na [3];
      logic [POS_W-1:0]   nb [3];
      logic [Q_W+1:0]     mv;
      logic               neg;
      logic               changed;
      pa[0] = md_ctl.item.p1x;
      pa[1] = md_ctl.item.p1y;
      pa[2] = md_ctl.item.p1z;
      pb[0] = md_ctl.item.p2x;
      pb[1] = md_ctl.item.p2y;
      pb[2] = md_ctl.item.p2z;
      changed = 1'b0;
      for (int i = 0; i < 3; i++) begin
         neg = ($signed(pb[i]) < $signed(pa[i])) ^ md_ctl.c_neg;
         mv  = neg ? -{2'b00, md_quo[i]} : {2'b00, md_quo[i]};
         na[i] = pa[i];
         nb[i] = pb[i];
         if (md_ctl.move && !md_ctl.item.pin1) begin
            na[i] = sat32({{(SUM_W-POS_W){pa[i][POS_W-1]}}, pa[i]} + {mv[Q_W+1], mv});
         end
         if (md_ctl.move && !md_ctl.item.pin2) begin
            nb[i] = sat32({{(SUM_W-POS_W){pb[i][POS_W-1]}}, pb[i]} - {mv[Q_W+1], mv});
         end
         if (na[i] != pa[i] || nb[i] != pb[i]) begin
            changed = 1'b1;
         end
      end
      rsp_data_in = {3'b000, md_ctl.item.idx2, md_ctl.item.idx1, changed,
                     nb[2], nb[1], nb[0], na[2], na[1], na[0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= md_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_no_move_no_flag: assert property (@(posedge clock) disable iff (reset)
      (adv && md_valid && !md_ctl.move) |=> !rsp_tdata[192])
      else $error("corrected flag set without a move");

   a_pinned_holds: assert property (@(posedge clock) disable iff (reset)
      (adv && md_valid && md_ctl.item.pin1) |=> (rsp_tdata[31:0] == $past(md_ctl.item.p1x)))
      else $error("anchored first endpoint moved");

   a_both_pinned: assert property (@(posedge clock) disable iff (reset)
      (p3_valid_ff && p3_ctl_ff.item.pin1 && p3_ctl_ff.item.pin2) |-> !p3_ctl_ff.move)
      else $error("move scheduled with both endpoints anchored");

endmodule
